// ===== hw/rtl/gregorian_to_jalali_date_unit_assert.svh =====
// Assertion macros shared by the Gregorian to Jalali date unit.
// The surrounding module must provide signals named clock and reset.
`ifndef GREGORIAN_TO_JALALI_DATE_UNIT_ASSERT_SVH
`define GREGORIAN_TO_JALALI_DATE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GJD_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("date unit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GJD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("date unit assertion failed");

`endif

// ===== hw/rtl/gjd_pkg.sv =====
// Shared constants, tables and stage types of the Gregorian to Jalali date unit.
// No dependencies.
package gjd_pkg;

   localparam int YEAR_OFFSET_W = 7;
   localparam int GREG_MONTH_W  = 4;
   localparam int GREG_DAY_W    = 5;
   localparam int JAL_YEAR_W    = 11;
   localparam int JAL_MONTH_W   = 4;
   localparam int JAL_DAY_W     = 5;
   localparam int DOY_W         = 9;

   localparam int BASE_YEAR        = 2000;
   localparam int SPRING_START     = 79;
   localparam int FIRST_HALF       = 186;
   localparam int YEAR_SHIFT_LATE  = 621;
   localparam int YEAR_SHIFT_EARLY = 622;
   localparam int LONG_MONTH_DAYS  = 31;
   localparam int SHORT_MONTH_DAYS = 30;
   localparam int MAX_QUOTIENT     = 6;

   // 2100 is the only non-leap century year in range.
   localparam int NONLEAP_CENTURY_OFFSET = 2100 - BASE_YEAR;

   localparam int JAL_YEAR_LATE  = BASE_YEAR - YEAR_SHIFT_LATE;
   localparam int JAL_YEAR_EARLY = BASE_YEAR - YEAR_SHIFT_EARLY;

   // Dey, month 10, starts after the first half plus three 30-day months.
   localparam int EARLY_DOY_BASE = FIRST_HALF + 3 * SHORT_MONTH_DAYS;

   // Month offsets added to the quotient in each section of the year.
   localparam logic [JAL_MONTH_W-1:0] MONTH_BASE_FIRST_HALF  = 4'd0;
   localparam logic [JAL_MONTH_W-1:0] MONTH_BASE_SECOND_HALF = 4'd6;
   localparam logic [JAL_MONTH_W-1:0] MONTH_BASE_WINTER      = 4'd9;

   localparam logic [GREG_MONTH_W-1:0] MONTH_JAN   = 4'd1;
   localparam logic [GREG_MONTH_W-1:0] MONTH_MAR   = 4'd3;
   localparam logic [GREG_MONTH_W-1:0] MONTH_DEC   = 4'd12;

   typedef struct packed {
      logic [YEAR_OFFSET_W-1:0] year_offset;
      logic [DOY_W-1:0]         doy;
      logic                     prev_leap;
   } doy_stage_type;

   typedef struct packed {
      logic [DOY_W-1:0]      num;
      logic                  late;
      logic                  first_half;
      logic [JAL_YEAR_W-1:0] jalali_year;
      logic [DOY_W-1:0]      jalali_day_of_year;
   } split_stage_type;

   // Days before each month of a common year, indexed by month minus one.
   function automatic logic [DOY_W-1:0] days_before(input logic [3:0] midx);
      logic [DOY_W-1:0] res;
      case (midx)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd59;
         4'd3:    res = 9'd90;
         4'd4:    res = 9'd120;
         4'd5:    res = 9'd151;
         4'd6:    res = 9'd181;
         4'd7:    res = 9'd212;
         4'd8:    res = 9'd243;
         4'd9:    res = 9'd273;
         4'd10:   res = 9'd304;
         4'd11:   res = 9'd334;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

// ===== hw/rtl/gjd_doy_stage.sv =====
// First pipeline stage: Gregorian day of year and leap flags.
// Depends on gjd_pkg.
module gjd_doy_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic [gjd_pkg::YEAR_OFFSET_W-1:0]    in_year_offset,
   input  logic [gjd_pkg::GREG_MONTH_W-1:0]     in_month,
   input  logic [gjd_pkg::GREG_DAY_W-1:0]       in_day,
   output logic                                 out_valid,
   output gjd_pkg::doy_stage_type               out_data
);

   logic                          valid_ff;
   gjd_pkg::doy_stage_type        data_ff;
   gjd_pkg::doy_stage_type        data_in;
   logic [3:0]                    midx;
   logic                          leap;
   logic                          prev_leap;

   always_comb begin
      // Month zero counts as January and anything past twelve as December.
      if (in_month < gjd_pkg::MONTH_JAN) begin
         midx = 4'd0;
      end else if (in_month > gjd_pkg::MONTH_DEC) begin
         midx = 4'(gjd_pkg::MONTH_DEC - 4'd1);
      end else begin
         midx = 4'(in_month - 4'd1);
      end
      leap = (in_year_offset[1:0] == 2'b00) &&
             (in_year_offset != 7'(gjd_pkg::NONLEAP_CENTURY_OFFSET));
      prev_leap = (in_year_offset[1:0] == 2'b01) &&
                  (in_year_offset != 7'(gjd_pkg::NONLEAP_CENTURY_OFFSET + 1));
      data_in.year_offset = in_year_offset;
      data_in.prev_leap   = prev_leap;
      data_in.doy = gjd_pkg::days_before(midx) + 9'(in_day) +
                    9'(leap && (in_month >= gjd_pkg::MONTH_MAR));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/gjd_split_stage.sv =====
// Second pipeline stage: picks the section of the Jalali year, the year number,
// the Jalali day of year and the day count to divide. Depends on gjd_pkg.
module gjd_split_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  gjd_pkg::doy_stage_type    in_data,
   output logic                      out_valid,
   output gjd_pkg::split_stage_type  out_data
);

   logic                          valid_ff;
   gjd_pkg::split_stage_type      data_ff;
   gjd_pkg::split_stage_type      data_in;
   logic [gjd_pkg::DOY_W-1:0]     t;
   logic [gjd_pkg::DOY_W-1:0]     early_num;
   logic                          late;
   logic                          first_half;

   always_comb begin
      late       = in_data.doy > 9'(gjd_pkg::SPRING_START);
      t          = in_data.doy - 9'(gjd_pkg::SPRING_START);
      first_half = t <= 9'(gjd_pkg::FIRST_HALF);
      early_num  = in_data.doy + (in_data.prev_leap ? 9'd11 : 9'd10);

      data_in.late       = late;
      data_in.first_half = first_half;
      if (late) begin
         data_in.num = first_half ? t : 9'(t - 9'(gjd_pkg::FIRST_HALF));
         // After the new year the Jalali day of year is the day count itself.
         data_in.jalali_day_of_year = t;
         data_in.jalali_year = 11'(in_data.year_offset) + 11'(gjd_pkg::JAL_YEAR_LATE);
      end else begin
         data_in.num = early_num;
         data_in.jalali_day_of_year = 9'(early_num + 9'(gjd_pkg::EARLY_DOY_BASE));
         data_in.jalali_year = 11'(in_data.year_offset) + 11'(gjd_pkg::JAL_YEAR_EARLY);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/gjd_month_stage.sv =====
// Third pipeline stage: divides the day count by the month length and forms
// the Jalali month and day; holds the result registers. Depends on gjd_pkg.
module gjd_month_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  gjd_pkg::split_stage_type            in_data,
   output logic                                out_valid,
   output logic [gjd_pkg::JAL_YEAR_W-1:0]      out_jalali_year,
   output logic [gjd_pkg::JAL_MONTH_W-1:0]     out_jalali_month,
   output logic [gjd_pkg::JAL_DAY_W-1:0]       out_jalali_day,
   output logic [gjd_pkg::DOY_W-1:0]           out_jalali_day_of_year
);

   logic                                valid_ff;
   logic [gjd_pkg::JAL_YEAR_W-1:0]      year_ff;
   logic [gjd_pkg::JAL_MONTH_W-1:0]     month_ff;
   logic [gjd_pkg::JAL_MONTH_W-1:0]     month_in;
   logic [gjd_pkg::JAL_DAY_W-1:0]       day_ff;
   logic [gjd_pkg::JAL_DAY_W-1:0]       day_in;
   logic [gjd_pkg::DOY_W-1:0]           jdoy_ff;
   logic [gjd_pkg::DOY_W-1:0]           divisor;
   logic [2:0]                          q;
   logic [gjd_pkg::DOY_W-1:0]           r;
   logic [gjd_pkg::JAL_MONTH_W-1:0]     base;

   always_comb begin
      if (in_data.late && in_data.first_half) begin
         divisor = 9'(gjd_pkg::LONG_MONTH_DAYS);
         base    = gjd_pkg::MONTH_BASE_FIRST_HALF;
      end else if (in_data.late) begin
         divisor = 9'(gjd_pkg::SHORT_MONTH_DAYS);
         base    = gjd_pkg::MONTH_BASE_SECOND_HALF;
      end else begin
         divisor = 9'(gjd_pkg::SHORT_MONTH_DAYS);
         base    = gjd_pkg::MONTH_BASE_WINTER;
      end
      // The count never reaches seven months, so six independent compares
      // give the quotient.
      q = 3'd0;
      for (int k = 1; k <= gjd_pkg::MAX_QUOTIENT; k++) begin
         if (in_data.num >= 9'(k) * divisor) begin
            q = q + 3'd1;
         end
      end
      r = in_data.num - 9'(q) * divisor;
      // An exact multiple lands on the last day of the preceding month.
      month_in = base + 4'(q) + 4'(r != 9'd0);
      day_in   = (r == 9'd0) ? divisor[4:0] : r[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      year_ff  <= in_data.jalali_year;
      month_ff <= month_in;
      day_ff   <= day_in;
      jdoy_ff  <= in_data.jalali_day_of_year;
   end

   assign out_valid              = valid_ff;
   assign out_jalali_year        = year_ff;
   assign out_jalali_month       = month_ff;
   assign out_jalali_day         = day_ff;
   assign out_jalali_day_of_year = jdoy_ff;

endmodule

// ===== hw/rtl/gregorian_to_jalali_date_unit.sv =====
// Gregorian to Jalali date converter, three register stages deep.
// An item taken by start passes through the doy, split and month stage registers in turn to rsp.
// Throughput: one item per cycle; busy stays low, as no stage ever waits.
// The third stage (a 31/30-day division by six compares) sets the clock path.
// Synchronous reset clears the stage valid bits; data registers are not reset.
module gregorian_to_jalali_date_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [gjd_pkg::YEAR_OFFSET_W-1:0]   req_greg_year_offset,
   input  logic [gjd_pkg::GREG_MONTH_W-1:0]    req_greg_month,
   input  logic [gjd_pkg::GREG_DAY_W-1:0]      req_greg_day,
   output logic                                rsp_valid,
   output logic [gjd_pkg::JAL_YEAR_W-1:0]      rsp_jalali_year,
   output logic [gjd_pkg::JAL_MONTH_W-1:0]     rsp_jalali_month,
   output logic [gjd_pkg::JAL_DAY_W-1:0]       rsp_jalali_day,
   output logic [gjd_pkg::DOY_W-1:0]           rsp_jalali_day_of_year
);

`include "gregorian_to_jalali_date_unit_assert.svh"

   logic                      accept;
   logic                      s1_valid;
   gjd_pkg::doy_stage_type    s1_data;
   logic                      s2_valid;
   gjd_pkg::split_stage_type  s2_data;
   logic                      rsp_first_half;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   gjd_doy_stage u_doy (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .in_year_offset (req_greg_year_offset),
      .in_month       (req_greg_month),
      .in_day         (req_greg_day),
      .out_valid      (s1_valid),
      .out_data       (s1_data)
   );

   gjd_split_stage u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   gjd_month_stage u_month (
      .clock                  (clock),
      .reset                  (reset),
      .in_valid               (s2_valid),
      .in_data                (s2_data),
      .out_valid              (rsp_valid),
      .out_jalali_year        (rsp_jalali_year),
      .out_jalali_month       (rsp_jalali_month),
      .out_jalali_day         (rsp_jalali_day),
      .out_jalali_day_of_year (rsp_jalali_day_of_year)
   );

   assign rsp_first_half = rsp_valid && (rsp_jalali_month < 4'd7);

   // A response appears only for an item taken through the stage registers; a taken item reaches the doy stage output.
   `GJD_ASSERT_SAME(a_rsp_from_item, rsp_valid, $past(accept, 3))
   `GJD_ASSERT_NEXT(a_item_reaches_mid, accept, s1_valid)
   `GJD_ASSERT_SAME(a_month_legal, rsp_valid, rsp_jalali_month >= 4'd1 && rsp_jalali_month <= 4'd12)
   `GJD_ASSERT_SAME(a_day_legal, rsp_valid, rsp_jalali_day >= 5'd1 && rsp_jalali_day <= 5'd31)
   `GJD_ASSERT_SAME(a_first_half_doy, rsp_first_half, rsp_jalali_day_of_year <= 9'd186)

endmodule
